// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, muted while rst_n is low
`define BFFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, including during reset
`define BFFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bffa_pkg.sv
// ---------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-fit allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bffa_pkg;

  // Fixed field widths
  localparam int unsigned LIM_W    = 14;
  localparam int unsigned STATUS_W = 2;
  // Largest supported word is 64 bits, so a bit index needs 6 bits
  localparam int unsigned IDX_W    = 6;

  // Parameter defaults
  localparam int unsigned MAP_BITS_DEF  = 8192;
  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned LIMIT_RESET   = 8192;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_ADDR,
    ST_FREE_CHK,
    ST_WRITE,
    ST_RESP
  } state_t;

  // Lowest-clear-bit search result
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } find_t;

endpackage

// File: rtl/core/bffa_map_ram.sv
// ---------------------------------------------------------------------------
// bffa_map_ram
// Used-bit map storage: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bffa_map_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bffa_word_find.sv
// ---------------------------------------------------------------------------
// bffa_word_find
// Finds the lowest clear bit of one map word among its valid low bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bffa_word_find #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned VW        = 7
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [VW-1:0]        valid_cnt,
  output logic [WORD_BITS-1:0] lowbit,
  output bffa_pkg::find_t      result
);

  import bffa_pkg::*;

  logic [WORD_BITS-1:0] cand;
  logic [IDX_W-1:0]     idx;

  // Clear bits below the valid count are candidates
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      cand[i] = !word[i] && (VW'(i) < valid_cnt);
    end
  end

  // Isolate the lowest candidate
  assign lowbit = cand & (~cand + WORD_BITS'(1));

  // One-hot to binary, each output bit an independent OR
  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      for (int j = 0; j < IDX_W; j++) begin
        if (((i >> j) & 1) != 0) begin
          idx[j] = idx[j] | lowbit[i];
        end
      end
    end
  end

  assign result.found = |cand;
  assign result.idx   = idx;

endmodule

// File: rtl/core/bitmap_first_fit_allocator_core.sv
// ---------------------------------------------------------------------------
// bitmap_first_fit_allocator_core
// Bitmap unit allocator: grants the lowest free unit, frees given units.
// ---------------------------------------------------------------------------
// After reset the block clears its map RAM, one word per cycle, with busy
// high. An item is taken when start is high and busy is low; busy then
// stays high until the item is done, and its result shows on the out_ ports
// for one cycle with out_valid, in the first cycle with busy low. There is
// no stall on the result side: the result must be captured when out_valid
// is high. An allocate scans the map one word per cycle from word 0 through
// the RAM read port until it finds a free unit or passes the unit limit.
// A free steps through read, check, write and respond when it clears a
// used unit, skips the write when the unit was already free, and goes
// straight to respond when the number is out of range. The unit limit
// may be written at any time; write it while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitmap_first_fit_allocator_core #(
  parameter int unsigned MAP_BITS  = bffa_pkg::MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bffa_pkg::LIM_W-1:0]    cfg_unit_limit,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [bffa_pkg::LIM_W-1:0]    in_unit_number,
  // result
  output logic                          out_valid,
  output logic [bffa_pkg::LIM_W-1:0]    out_granted_number,
  output logic [bffa_pkg::STATUS_W-1:0] out_status,
  output logic [bffa_pkg::LIM_W-1:0]    out_free_units
);

  import bffa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SW        = $clog2(WORD_BITS);
  localparam int unsigned VW        = $clog2(WORD_BITS + 1);
  localparam int unsigned BW        = $clog2(MAP_BITS + 2 * WORD_BITS);
  localparam int unsigned CW        = (BW > LIM_W) ? BW : LIM_W;
  // word index = (n * RECIP) >> DIV_SH, exact for all n below 2**LIM_W
  localparam int unsigned DIV_SH    = LIM_W + SW;
  localparam int unsigned RECIP     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

  // Control and datapath registers
  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [LIM_W-1:0]     unit_limit_r;
  logic [LIM_W-1:0]     used_r, used_nxt;
  logic                 kind_r, kind_nxt;
  logic [LIM_W-1:0]     num_m1_r, num_m1_nxt;
  logic [AW-1:0]        word_addr_r, word_addr_nxt;
  logic [SW-1:0]        bit_r, bit_nxt;
  logic [AW-1:0]        issue_addr_r, issue_addr_nxt;
  logic [CW-1:0]        issue_base_r, issue_base_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [AW-1:0]        chk_addr_r, chk_addr_nxt;
  logic [CW-1:0]        chk_base_r, chk_base_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [LIM_W-1:0]     grant_r, grant_nxt;
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LIM_W-1:0]     out_granted_r, out_granted_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [LIM_W-1:0]     out_free_r, out_free_nxt;

  // Memory port signals
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Misc combinational
  logic [LIM_W-1:0]     lim;
  logic [CW-1:0]        lim_cw;
  logic                 accept;
  logic                 issue_now;
  logic [CW-1:0]        rem;
  logic [VW-1:0]        valid_cnt;
  logic [WORD_BITS-1:0] lowbit;
  find_t                find;
  logic [31:0]          div_prod;
  logic                 num_bad;

  // Effective limit: register saturated to the map size
  assign lim    = (CW'(unit_limit_r) > CW'(MAP_BITS)) ? LIM_W'(MAP_BITS) : unit_limit_r;
  assign lim_cw = CW'(lim);

  assign accept    = start && (state_r == ST_IDLE);
  assign issue_now = (state_r == ST_SCAN) && (issue_base_r < lim_cw);

  // Valid bits of the word under check: those below the limit
  assign rem       = lim_cw - chk_base_r;
  assign valid_cnt = (rem >= CW'(WORD_BITS)) ? VW'(WORD_BITS) : VW'(rem);

  // Word index of a freed unit via reciprocal multiply
  assign div_prod = 32'(in_unit_number - LIM_W'(1)) * 32'(RECIP);
  assign num_bad  = (in_unit_number == '0) || (in_unit_number > lim);

  bffa_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bffa_word_find #(
    .WORD_BITS (WORD_BITS),
    .VW        (VW)
  ) u_word_find (
    .word      (ram_rdata),
    .valid_cnt (valid_cnt),
    .lowbit    (lowbit),
    .result    (find)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_kind == KIND_ALLOC) begin
            state_nxt = ST_SCAN;
          end else if (num_bad) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_FREE_ADDR;
          end
        end
      end
      ST_SCAN: begin
        if (chk_v_r && find.found) begin
          state_nxt = ST_WRITE;
        end else if (!issue_now) begin
          state_nxt = ST_RESP;
        end
      end
      ST_FREE_ADDR: state_nxt = ST_FREE_CHK;
      ST_FREE_CHK: begin
        state_nxt = ram_rdata[bit_r] ? ST_WRITE : ST_RESP;
      end
      ST_WRITE: state_nxt = ST_RESP;
      ST_RESP:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memory port control and busy
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_addr_r;
    ram_wdata = word_r;
    ram_re    = 1'b0;
    ram_raddr = issue_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_SCAN: begin
        ram_re = issue_now;
      end
      ST_FREE_ADDR: begin
        ram_re    = 1'b1;
        ram_raddr = word_addr_r;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Datapath next values
  always_comb begin
    clr_addr_nxt    = clr_addr_r;
    used_nxt        = used_r;
    kind_nxt        = kind_r;
    num_m1_nxt      = num_m1_r;
    word_addr_nxt   = word_addr_r;
    bit_nxt         = bit_r;
    issue_addr_nxt  = issue_addr_r;
    issue_base_nxt  = issue_base_r;
    chk_v_nxt       = 1'b0;
    chk_addr_nxt    = chk_addr_r;
    chk_base_nxt    = chk_base_r;
    word_nxt        = word_r;
    grant_nxt       = grant_r;
    status_nxt      = status_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_free_nxt    = out_free_r;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          kind_nxt       = in_kind;
          num_m1_nxt     = in_unit_number - LIM_W'(1);
          word_addr_nxt  = AW'(div_prod >> DIV_SH);
          issue_addr_nxt = '0;
          issue_base_nxt = '0;
          grant_nxt      = '0;
          status_nxt     = STAT_OK;
          if (in_kind == KIND_FREE && num_bad) begin
            status_nxt = STAT_RANGE;
          end
        end
      end
      ST_SCAN: begin
        // read the next word while the previous one is checked
        if (issue_now) begin
          issue_addr_nxt = issue_addr_r + AW'(1);
          issue_base_nxt = issue_base_r + CW'(WORD_BITS);
        end
        chk_v_nxt    = issue_now;
        chk_addr_nxt = issue_addr_r;
        chk_base_nxt = issue_base_r;
        if (chk_v_r && find.found) begin
          word_addr_nxt = chk_addr_r;
          word_nxt      = ram_rdata | lowbit;
          grant_nxt     = LIM_W'(chk_base_r + CW'(find.idx) + CW'(1));
        end else if (!issue_now) begin
          status_nxt = STAT_NO_FREE;
        end
      end
      ST_FREE_ADDR: begin
        bit_nxt = SW'(CW'(num_m1_r) - CW'(word_addr_r) * CW'(WORD_BITS));
      end
      ST_FREE_CHK: begin
        word_nxt = ram_rdata & ~(WORD_BITS'(1) << bit_r);
      end
      ST_WRITE: begin
        // count follows the bit that was changed
        if (kind_r == KIND_ALLOC) begin
          used_nxt = used_r + LIM_W'(1);
        end else if (used_r != '0) begin
          used_nxt = used_r - LIM_W'(1);
        end
      end
      ST_RESP: begin
        out_valid_nxt   = 1'b1;
        out_granted_nxt = grant_r;
        out_status_nxt  = status_r;
        out_free_nxt    = (lim > used_r) ? (lim - used_r) : '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      used_r       <= '0;
      unit_limit_r <= LIM_W'(LIMIT_RESET);
      chk_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      used_r      <= used_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unit_limit_r <= cfg_unit_limit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    num_m1_r      <= num_m1_nxt;
    word_addr_r   <= word_addr_nxt;
    bit_r         <= bit_nxt;
    issue_addr_r  <= issue_addr_nxt;
    issue_base_r  <= issue_base_nxt;
    chk_addr_r    <= chk_addr_nxt;
    chk_base_r    <= chk_base_nxt;
    word_r        <= word_nxt;
    grant_r       <= grant_nxt;
    status_r      <= status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted_number = out_granted_r;
  assign out_status         = out_status_r;
  assign out_free_units     = out_free_r;

  // Assertions
  `BFFA_ASSERT(a_no_rw_same_word, (ram_re && ram_we) |-> (ram_raddr != ram_waddr), "map read and write hit the same word")
  `BFFA_ASSERT(a_result_from_resp, out_valid_r |-> $past(state_r == ST_RESP), "result strobe without respond state")
  `BFFA_ASSERT(a_count_moves_on_write, (used_r != $past(used_r)) |-> $past(state_r == ST_WRITE), "in-use count changed outside write-back")
  `BFFA_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid && busy), "reset must start the clearing pass")

endmodule

// File: tb/bitmap_first_fit_allocator_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_first_fit_allocator_core_tb
// Drives allocate and free items into the allocator and checks every result
// against a shadow copy of the used-unit map, the in-use count and the unit
// limit. Directed tests cover the field extremes and the limit corner cases.
// Random phases then run mostly in-range frees and allocations at several
// limits, with sender gaps that are light, heavy or absent.
// ---------------------------------------------------------------------------

module bitmap_first_fit_allocator_core_tb;
  import bffa_pkg::*;

  localparam int unsigned UNITS       = MAP_BITS_DEF;
  localparam int unsigned NUM_MAX     = (1 << LIM_W) - 1;
  localparam int unsigned STALL_LIMIT = 4000;

  // One result item as the block reports it
  typedef struct {
    logic [LIM_W-1:0] granted;
    status_t          status;
    logic [LIM_W-1:0] free_cnt;
  } reply_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LIM_W-1:0]    cfg_unit_limit;
  logic                start;
  logic                busy;
  logic                in_kind;
  logic [LIM_W-1:0]    in_unit_number;
  logic                out_valid;
  logic [LIM_W-1:0]    out_granted_number;
  logic [STATUS_W-1:0] out_status;
  logic [LIM_W-1:0]    out_free_units;

  // Shadow state of the allocator
  bit               used_bits [UNITS];
  int unsigned      units_in_use;
  logic [LIM_W-1:0] limit_shadow;
  int unsigned      top_unit;

  reply_t      reply_q[$];
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  int unsigned sender_idle_pct;

  bitmap_first_fit_allocator_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_unit_limit     (cfg_unit_limit),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_unit_number     (in_unit_number),
    .out_valid          (out_valid),
    .out_granted_number (out_granted_number),
    .out_status         (out_status),
    .out_free_units     (out_free_units)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned effective_limit();
    int unsigned lim;
    lim = limit_shadow;
    if (lim > UNITS) lim = UNITS;
    return lim;
  endfunction

  // Apply one item to the shadow state and return the result it causes
  function automatic reply_t apply_request(logic kind, logic [LIM_W-1:0] num);
    reply_t      r;
    int unsigned lim;
    lim        = effective_limit();
    r.granted  = '0;
    r.status   = STAT_OK;
    if (kind == KIND_ALLOC) begin
      r.status = STAT_NO_FREE;
      for (int unsigned b = 0; b < lim; b++) begin
        if (!used_bits[b]) begin
          used_bits[b] = 1'b1;
          units_in_use++;
          r.granted = LIM_W'(b + 1);
          r.status  = STAT_OK;
          if (b + 1 > top_unit) top_unit = b + 1;
          break;
        end
      end
    end else if (num == 0 || num > lim) begin
      r.status = STAT_RANGE;
    end else if (used_bits[num-1]) begin
      // freeing a clear unit leaves map and count alone
      used_bits[num-1] = 1'b0;
      if (units_in_use > 0) units_in_use--;
    end
    r.free_cnt = (lim > units_in_use) ? LIM_W'(lim - units_in_use) : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one item: optional sender gap, then hold start until taken
  task automatic send_request(input logic kind, input logic [LIM_W-1:0] num);
    int unsigned gaps;
    gaps = 0;
    while (gaps < 16 && $urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      gaps++;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_kind        <= kind;
    in_unit_number <= num;
    @(posedge clk);
    while (busy) @(posedge clk);
    reply_q.push_back(apply_request(kind, num));
  endtask

  // Drop start and wait until every result is in and the block is idle
  task automatic settle_block();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0 || busy) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_unit_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic at one limit; frees mostly aim at units handed out so far
  task automatic random_phase(input int unsigned n_items, input logic [LIM_W-1:0] lim);
    int unsigned eff;
    int unsigned pick;
    int unsigned alloc_pct;
    logic [LIM_W-1:0] num;
    write_limit(lim);
    repeat (n_items) begin
      eff       = effective_limit();
      alloc_pct = (units_in_use >= eff) ? 35 : 55;
      if ($urandom_range(99) < alloc_pct) begin
        send_request(KIND_ALLOC, LIM_W'($urandom_range(NUM_MAX)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 80)
          num = LIM_W'($urandom_range(1, (top_unit > 0) ? top_unit : 1));
        else if (pick < 87)
          num = '0;
        else if (pick < 94)
          num = LIM_W'($urandom_range(eff + 1, NUM_MAX));
        else
          num = LIM_W'($urandom_range(NUM_MAX));
        send_request(KIND_FREE, num);
      end
    end
  endtask

  // Default limit straight out of reset
  task automatic test_reset_limit();
    send_request(KIND_ALLOC, '0);
    send_request(KIND_ALLOC, LIM_W'(NUM_MAX));
    send_request(KIND_FREE, LIM_W'(1));
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, '0);
    send_request(KIND_FREE, LIM_W'(UNITS));
    send_request(KIND_FREE, LIM_W'(UNITS + 1));
    send_request(KIND_FREE, LIM_W'(NUM_MAX));
    send_request(KIND_FREE, LIM_W'(5));
  endtask

  // Limit of zero, limit past the map size, limit of one
  task automatic test_limit_extremes();
    write_limit('0);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, LIM_W'(1));
    write_limit(LIM_W'(NUM_MAX));
    send_request(KIND_FREE, LIM_W'(UNITS));
    send_request(KIND_FREE, LIM_W'(UNITS + 1));
    write_limit(LIM_W'(1));
    send_request(KIND_ALLOC, '0);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, LIM_W'(1));
  endtask

  // Limit dropped under the units in use: zero free, stranded units
  task automatic test_limit_below_use();
    write_limit(LIM_W'(64));
    repeat (6) send_request(KIND_ALLOC, '0);
    write_limit(LIM_W'(3));
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, LIM_W'(5));
    send_request(KIND_FREE, LIM_W'(2));
  endtask

  task automatic test_sender_light_gaps();
    sender_idle_pct = 22;
    random_phase(200, LIM_W'(UNITS));
    random_phase(200, LIM_W'($urandom_range(1, 40)));
    random_phase(150, LIM_W'(64));
  endtask

  task automatic test_sender_heavy_gaps();
    sender_idle_pct = 61;
    random_phase(150, LIM_W'(1));
    random_phase(200, LIM_W'(65));
    random_phase(150, LIM_W'(NUM_MAX));
    random_phase(100, LIM_W'($urandom_range(100, 300)));
  endtask

  task automatic test_back_to_back();
    sender_idle_pct = 0;
    random_phase(200, LIM_W'(128));
    random_phase(50, '0);
    random_phase(200, LIM_W'($urandom_range(2, 20)));
    random_phase(200, LIM_W'(UNITS));
  endtask

  // Compare each result with the oldest expected one
  always @(posedge clk) begin : check_replies
    reply_t exp_r;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        exp_r = reply_q.pop_front();
        if (out_granted_number !== exp_r.granted)
          report_mismatch($sformatf("granted_number got %0d exp %0d",
                                    out_granted_number, exp_r.granted));
        if (out_status !== exp_r.status)
          report_mismatch($sformatf("status got %0d exp %0d", out_status, exp_r.status));
        if (out_free_units !== exp_r.free_cnt)
          report_mismatch($sformatf("free_units got %0d exp %0d",
                                    out_free_units, exp_r.free_cnt));
      end
    end
  end

  // Watchdog: cycles with no item, result or register write taken
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_unit_limit  = '0;
    start           = 1'b0;
    in_kind         = KIND_ALLOC;
    in_unit_number  = '0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    sender_idle_pct = 0;
    units_in_use    = 0;
    top_unit        = 0;
    limit_shadow    = LIM_W'(LIMIT_RESET);
    foreach (used_bits[i]) used_bits[i] = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_limit();
    test_limit_extremes();
    test_limit_below_use();
    test_sender_light_gaps();
    test_sender_heavy_gaps();
    test_back_to_back();

    settle_block();
    repeat (10) @(posedge clk);
    if (reply_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", reply_q.size()));
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
